// ===== hdl/mhpq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_pkg: shared types and constants for the min-heap priority queue
// Sizes, operation and status codes, and the stored heap entry layout.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  localparam int DEPTH        = 256;
  localparam int KEY_WIDTH    = 32;
  localparam int HANDLE_WIDTH = 16;

  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CHILD_W = ADDR_W + 1;
  localparam int CAP_W   = 9;
  localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int ENTRY_W = KEY_WIDTH + HANDLE_WIDTH;

  localparam logic [1:0] MODE_INSERT   = 2'd0;
  localparam logic [1:0] MODE_DECREASE = 2'd1;
  localparam logic [1:0] MODE_EXTRACT  = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
  localparam logic [1:0] STATUS_EMPTY     = 2'd3;

  typedef struct packed {
    logic signed [KEY_WIDTH-1:0] key;
    logic [HANDLE_WIDTH-1:0]     handle;
  } entry_t;

endpackage

// ===== hdl/mhpq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mhpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/mhpq_cmp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_cmp: shared signed key comparator
// Reports whether key a orders strictly before key b.
// ----------------------------------------------------------------------------
module mhpq_cmp
  import mhpq_pkg::*;
(
  input  logic signed [KEY_WIDTH-1:0] a,
  input  logic signed [KEY_WIDTH-1:0] b,
  output logic                        lt
);

  assign lt = ($signed(a) < $signed(b));

endmodule

// ===== hdl/min_heap_priority_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_heap_priority_queue_top: binary min-heap of (key, handle) pairs
// Insert, decrease-key and extract-min on a RAM-backed heap, one item at a time.
// ----------------------------------------------------------------------------
// The heap lives in one RAM with a single read port and registered read data,
// and a small sequencer walks it with at most one memory read per cycle, using
// one shared signed comparator for every key decision. Each item gives exactly
// one result item. An insert rises L levels (at most 8 for 256 entries), and
// each level reads the parent of the hole and then compares and writes back.
// A decrease-key first scans the handles in array order, one entry per cycle,
// until the first match or the end of the heap; a match rises like an insert.
// An extract-min reads the root and then the last entry and sinks that entry
// level by level; each level reads the left and then, if there is one, the
// right child through the single read port before it compares and writes
// back, and an extract that empties the heap skips the sift-down. The block
// does not take a new item while one is in progress, but it does take one
// while the previous result item is still waiting on res_stall. The capacity
// register may be written only while the block is idle; values above the RAM
// depth act as the depth, and zero makes every insert overflow.
// ----------------------------------------------------------------------------
module min_heap_priority_queue_top
  import mhpq_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst,
  // Configuration: capacity limit.
  input  logic                           cfg_we,
  input  logic [CAP_W-1:0]               cfg_data,
  // Operation channel.
  input  logic                           op_valid,
  output logic                           op_stall,
  input  logic [1:0]                     mode,
  input  logic signed [KEY_WIDTH-1:0]    key,
  input  logic [HANDLE_WIDTH-1:0]        handle,
  // Result channel.
  output logic                           res_valid,
  input  logic                           res_stall,
  output logic [1:0]                     status,
  output logic signed [KEY_WIDTH-1:0]    min_key,
  output logic [HANDLE_WIDTH-1:0]        min_handle,
  output logic [CNT_W-1:0]               entry_count
);

  // Sequencer states.
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SU_RD   = 4'd1;
  localparam logic [3:0] S_SU_CMP  = 4'd2;
  localparam logic [3:0] S_SRCH    = 4'd3;
  localparam logic [3:0] S_EX_ROOT = 4'd4;
  localparam logic [3:0] S_EX_LAST = 4'd5;
  localparam logic [3:0] S_SD_L    = 4'd6;
  localparam logic [3:0] S_SD_R    = 4'd7;
  localparam logic [3:0] S_SD_C    = 4'd8;
  localparam logic [3:0] S_SD_D    = 4'd9;
  localparam logic [3:0] S_FIN     = 4'd10;

  logic [3:0]              state, state_next;
  logic [CNT_W-1:0]        fill, fill_next;
  logic [CAP_W-1:0]        cap;
  logic [ADDR_W-1:0]       pos, pos_next;
  entry_t                  cur, cur_next;
  entry_t                  best, best_next;
  logic                    best_child, best_child_next;
  logic [ADDR_W-1:0]       best_idx, best_idx_next;
  logic [CNT_W-1:0]        scan, scan_next;
  logic [ADDR_W-1:0]       scan_prev, scan_prev_next;
  logic                    scan_vld, scan_vld_next;
  logic [1:0]              res_status, res_status_next;
  logic signed [KEY_WIDTH-1:0] res_key, res_key_next;
  logic [HANDLE_WIDTH-1:0] res_handle, res_handle_next;
  logic                    res_valid_next;
  logic [1:0]              status_next;
  logic signed [KEY_WIDTH-1:0] min_key_next;
  logic [HANDLE_WIDTH-1:0] min_handle_next;
  logic [CNT_W-1:0]        entry_count_next;

  // Memory port and shared comparator.
  logic                    wr_en;
  logic [ADDR_W-1:0]       wr_addr;
  entry_t                  wr_data;
  logic [ADDR_W-1:0]       rd_addr;
  entry_t                  rd_data;
  logic signed [KEY_WIDTH-1:0] cmp_a, cmp_b;
  logic                    cmp_lt;

  logic [CHILD_W-1:0]      l_idx, r_idx, fill_ext;
  logic [ADDR_W-1:0]       parent;
  logic                    accept;
  logic                    overflow;

  mhpq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mhpq_cmp u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .lt (cmp_lt)
  );

  assign op_stall = (state != S_IDLE);
  assign accept   = op_valid && !op_stall;

  // Children of the current hole, and its parent.
  assign l_idx    = {pos, 1'b1};
  assign r_idx    = l_idx + CHILD_W'(1);
  assign fill_ext = CHILD_W'(fill);
  assign parent   = (pos - ADDR_W'(1)) >> 1;

  // An insert overflows at the configured limit or at the RAM depth.
  assign overflow = (CMP_W'(fill) >= CMP_W'(cap)) || (fill >= CNT_W'(DEPTH));

  always_comb begin
    state_next       = state;
    fill_next        = fill;
    pos_next         = pos;
    cur_next         = cur;
    best_next        = best;
    best_child_next  = best_child;
    best_idx_next    = best_idx;
    scan_next        = scan;
    scan_prev_next   = scan_prev;
    scan_vld_next    = scan_vld;
    res_status_next  = res_status;
    res_key_next     = res_key;
    res_handle_next  = res_handle;
    status_next      = status;
    min_key_next     = min_key;
    min_handle_next  = min_handle;
    entry_count_next = entry_count;
    res_valid_next   = res_valid && res_stall;
    wr_en            = 1'b0;
    wr_addr          = pos;
    wr_data          = cur;
    rd_addr          = '0;
    cmp_a            = cur.key;
    cmp_b            = rd_data.key;

    case (state)
      S_IDLE: begin
        if (accept) begin
          res_status_next = STATUS_OK;
          res_key_next    = '0;
          res_handle_next = '0;
          case (mode)
            MODE_INSERT: begin
              if (overflow) begin
                res_status_next = STATUS_OVERFLOW;
                state_next      = S_FIN;
              end else begin
                cur_next   = '{key: key, handle: handle};
                pos_next   = fill[ADDR_W-1:0];
                fill_next  = fill + CNT_W'(1);
                state_next = S_SU_RD;
              end
            end
            MODE_DECREASE: begin
              cur_next      = '{key: key, handle: handle};
              scan_next     = '0;
              scan_vld_next = 1'b0;
              state_next    = S_SRCH;
            end
            MODE_EXTRACT: begin
              if (fill == '0) begin
                res_status_next = STATUS_EMPTY;
                state_next      = S_FIN;
              end else begin
                rd_addr    = '0;
                fill_next  = fill - CNT_W'(1);
                state_next = S_EX_ROOT;
              end
            end
            default: begin
              state_next = S_FIN;
            end
          endcase
        end
      end

      // The moving entry is kept in cur; the RAM slot at pos is a hole.
      S_SU_RD: begin
        if (pos == '0) begin
          wr_en      = 1'b1;
          state_next = S_FIN;
        end else begin
          rd_addr    = parent;
          state_next = S_SU_CMP;
        end
      end

      S_SU_CMP: begin
        cmp_a = cur.key;
        cmp_b = rd_data.key;
        wr_en = 1'b1;
        if (cmp_lt) begin
          wr_data    = rd_data;
          pos_next   = parent;
          state_next = S_SU_RD;
        end else begin
          state_next = S_FIN;
        end
      end

      // Handle scan, one read issued per cycle, checked once its read data is back.
      S_SRCH: begin
        if (scan_vld && (rd_data.handle == cur.handle)) begin
          pos_next      = scan_prev;
          scan_vld_next = 1'b0;
          state_next    = S_SU_RD;
        end else if (scan < fill) begin
          rd_addr        = scan[ADDR_W-1:0];
          scan_prev_next = scan[ADDR_W-1:0];
          scan_next      = scan + CNT_W'(1);
          scan_vld_next  = 1'b1;
        end else if (scan_vld) begin
          scan_vld_next = 1'b0;
        end else begin
          res_status_next = STATUS_NOT_FOUND;
          state_next      = S_FIN;
        end
      end

      S_EX_ROOT: begin
        res_key_next    = rd_data.key;
        res_handle_next = rd_data.handle;
        if (fill == '0) begin
          state_next = S_FIN;
        end else begin
          rd_addr    = fill[ADDR_W-1:0];
          state_next = S_EX_LAST;
        end
      end

      S_EX_LAST: begin
        cur_next   = rd_data;
        pos_next   = '0;
        state_next = S_SD_L;
      end

      S_SD_L: begin
        if (l_idx >= fill_ext) begin
          wr_en      = 1'b1;
          state_next = S_FIN;
        end else begin
          rd_addr    = l_idx[ADDR_W-1:0];
          state_next = S_SD_R;
        end
      end

      S_SD_R: begin
        cmp_a           = rd_data.key;
        cmp_b           = cur.key;
        best_child_next = cmp_lt;
        best_next       = cmp_lt ? rd_data : cur;
        best_idx_next   = l_idx[ADDR_W-1:0];
        if (r_idx < fill_ext) begin
          rd_addr    = r_idx[ADDR_W-1:0];
          state_next = S_SD_C;
        end else begin
          state_next = S_SD_D;
        end
      end

      // The left child keeps a tie with the right one.
      S_SD_C: begin
        cmp_a = rd_data.key;
        cmp_b = best.key;
        if (cmp_lt) begin
          best_child_next = 1'b1;
          best_next       = rd_data;
          best_idx_next   = r_idx[ADDR_W-1:0];
        end
        state_next = S_SD_D;
      end

      S_SD_D: begin
        wr_en = 1'b1;
        if (best_child) begin
          wr_data    = best;
          pos_next   = best_idx;
          state_next = S_SD_L;
        end else begin
          state_next = S_FIN;
        end
      end

      S_FIN: begin
        if (!res_valid || !res_stall) begin
          status_next      = res_status;
          min_key_next     = res_key;
          min_handle_next  = res_handle;
          entry_count_next = fill;
          res_valid_next   = 1'b1;
          state_next       = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      cap       <= CAP_W'(256);
      scan_vld  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      scan_vld  <= scan_vld_next;
      res_valid <= res_valid_next;
      if (cfg_we) begin
        cap <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos         <= pos_next;
    cur         <= cur_next;
    best        <= best_next;
    best_child  <= best_child_next;
    best_idx    <= best_idx_next;
    scan        <= scan_next;
    scan_prev   <= scan_prev_next;
    res_status  <= res_status_next;
    res_key     <= res_key_next;
    res_handle  <= res_handle_next;
    status      <= status_next;
    min_key     <= min_key_next;
    min_handle  <= min_handle_next;
    entry_count <= entry_count_next;
  end

`ifndef SYNTHESIS
  // The heap never holds more entries than the RAM has rows.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(DEPTH))
    else $error("heap fill count exceeds depth");

  // An accepted item always starts the sequencer.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("accepted item did not leave idle");

  // The heap RAM is written only while an item is being processed.
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> ((state != S_IDLE) && (state != S_FIN)))
    else $error("heap RAM written outside an operation");

  // A rising hole always sits inside the occupied part of the heap.
  a_pos_in_heap: assert property (@(posedge clk) disable iff (rst)
    (state == S_SU_RD) |-> (CNT_W'(pos) < fill))
    else $error("sift position outside the heap");
`endif

endmodule

// ===== dv/tb_min_heap_priority_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_min_heap_priority_queue_top: self-checking bench for the min-heap queue
// Runs a table of directed operations, a fill to full depth, and then random
// phases at many capacity settings. Every result item is checked field by
// field against a typed result or an in-bench heap copy updated at each send.
// ----------------------------------------------------------------------------
module tb_min_heap_priority_queue_top;
  import mhpq_pkg::*;

  // The one mode value that the block ignores.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // One result item as the block presents it.
  typedef struct packed {
    logic [1:0]                  status;
    logic signed [KEY_WIDTH-1:0] min_key;
    logic [HANDLE_WIDTH-1:0]     min_handle;
    logic [CNT_W-1:0]            entry_count;
  } heap_result_t;

  // One line of the directed table: either a capacity write or an operation,
  // optionally with a result typed in by hand.
  typedef struct packed {
    bit                          is_cap;
    logic [CAP_W-1:0]            cap;
    logic [1:0]                  op;
    logic signed [KEY_WIDTH-1:0] k;
    logic [HANDLE_WIDTH-1:0]     h;
    bit                          typed;
    heap_result_t                want;
  } heap_row_t;

  logic                        clk;
  logic                        rst;
  logic                        cfg_we;
  logic [CAP_W-1:0]            cfg_data;
  logic                        op_valid;
  logic                        op_stall;
  logic [1:0]                  op_mode;
  logic signed [KEY_WIDTH-1:0] op_key;
  logic [HANDLE_WIDTH-1:0]     op_handle;
  logic                        res_valid;
  logic                        res_stall;
  logic [1:0]                  status;
  logic signed [KEY_WIDTH-1:0] min_key;
  logic [HANDLE_WIDTH-1:0]     min_handle;
  logic [CNT_W-1:0]            entry_count;

  min_heap_priority_queue_top dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .op_valid    (op_valid),
    .op_stall    (op_stall),
    .mode        (op_mode),
    .key         (op_key),
    .handle      (op_handle),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .status      (status),
    .min_key     (min_key),
    .min_handle  (min_handle),
    .entry_count (entry_count)
  );

  // 2 ns clock.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow heap. It mirrors the block's array, fill count and capacity, and is
  // advanced in the order in which operations are handed to the block.
  // --------------------------------------------------------------------------
  logic signed [KEY_WIDTH-1:0] shadow_key    [DEPTH];
  logic [HANDLE_WIDTH-1:0]     shadow_handle [DEPTH];
  int                          shadow_fill = 0;
  int                          shadow_cap  = 256;

  heap_result_t  expected_results [$];
  heap_row_t     directed_rows [$];

  int  mismatch_count = 0;
  int  results_ok     = 0;
  int  peak_fill      = 0;
  int  cap_writes     = 0;
  int  sent_per_mode [4];
  bit  tx_calm = 1'b0;
  bit  rx_calm = 1'b0;

  function automatic void swap_shadow(int a, int b);
    logic signed [KEY_WIDTH-1:0] tk;
    logic [HANDLE_WIDTH-1:0]     th;
    tk = shadow_key[a];
    th = shadow_handle[a];
    shadow_key[a]    = shadow_key[b];
    shadow_handle[a] = shadow_handle[b];
    shadow_key[b]    = tk;
    shadow_handle[b] = th;
  endfunction

  // An entry rises only while its parent holds a strictly larger key.
  function automatic void rise_shadow(int pos);
    int up;
    while (pos != 0) begin
      up = (pos - 1) / 2;
      if (!(shadow_key[up] > shadow_key[pos])) break;
      swap_shadow(pos, up);
      pos = up;
    end
  endfunction

  // An entry sinks toward the strictly smaller child; the left child wins ties.
  function automatic void sink_shadow(int pos);
    int lc;
    int rc;
    int best;
    forever begin
      lc   = 2 * pos + 1;
      rc   = 2 * pos + 2;
      best = pos;
      if (lc < shadow_fill && shadow_key[lc] < shadow_key[best]) best = lc;
      if (rc < shadow_fill && shadow_key[rc] < shadow_key[best]) best = rc;
      if (best == pos) break;
      swap_shadow(pos, best);
      pos = best;
    end
  endfunction

  // Applies one operation to the shadow heap and returns the result item
  // that the block must give for it.
  function automatic heap_result_t apply_heap_op(logic [1:0] op,
                                                 logic signed [KEY_WIDTH-1:0] k,
                                                 logic [HANDLE_WIDTH-1:0] h);
    heap_result_t r;
    int           eff_cap;
    int           j;
    int           hit;
    r       = '0;
    eff_cap = (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
    case (op)
      MODE_INSERT: begin
        if (shadow_fill >= eff_cap) begin
          r.status = STATUS_OVERFLOW;
        end else begin
          shadow_key[shadow_fill]    = k;
          shadow_handle[shadow_fill] = h;
          shadow_fill++;
          rise_shadow(shadow_fill - 1);
        end
      end
      MODE_DECREASE: begin
        // The first match in array order is the one that changes.
        hit = -1;
        for (j = 0; j < shadow_fill && hit < 0; j++)
          if (shadow_handle[j] == h) hit = j;
        if (hit < 0) begin
          r.status = STATUS_NOT_FOUND;
        end else begin
          shadow_key[hit] = k;
          rise_shadow(hit);
        end
      end
      MODE_EXTRACT: begin
        if (shadow_fill == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.min_key    = shadow_key[0];
          r.min_handle = shadow_handle[0];
          shadow_fill--;
          if (shadow_fill > 0) begin
            shadow_key[0]    = shadow_key[shadow_fill];
            shadow_handle[0] = shadow_handle[shadow_fill];
            sink_shadow(0);
          end
        end
      end
      default: ;
    endcase
    r.entry_count = CNT_W'(shadow_fill);
    if (shadow_fill > peak_fill) peak_fill = shadow_fill;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Directed table builders.
  // --------------------------------------------------------------------------
  function automatic void plan_capacity(logic [CAP_W-1:0] v);
    heap_row_t r;
    r        = '0;
    r.is_cap = 1'b1;
    r.cap    = v;
    directed_rows.push_back(r);
  endfunction

  function automatic void plan_op(logic [1:0] op, logic signed [KEY_WIDTH-1:0] k,
                                  logic [HANDLE_WIDTH-1:0] h);
    heap_row_t r;
    r    = '0;
    r.op = op;
    r.k  = k;
    r.h  = h;
    directed_rows.push_back(r);
  endfunction

  function automatic void plan_checked(logic [1:0] op, logic signed [KEY_WIDTH-1:0] k,
                                       logic [HANDLE_WIDTH-1:0] h, logic [1:0] st,
                                       logic signed [KEY_WIDTH-1:0] mk,
                                       logic [HANDLE_WIDTH-1:0] mh, int cnt);
    heap_row_t r;
    r       = '0;
    r.op    = op;
    r.k     = k;
    r.h     = h;
    r.typed = 1'b1;
    r.want  = {st, mk, mh, CNT_W'(cnt)};
    directed_rows.push_back(r);
  endfunction

  // --------------------------------------------------------------------------
  // Random field generators.
  // --------------------------------------------------------------------------
  // Keys are a mix of full-range values, a narrow band from -16 to 0 that makes
  // ties common, and the two extremes.
  function automatic logic signed [KEY_WIDTH-1:0] random_key();
    case ($urandom_range(0, 3))
      0:       return $signed($urandom_range(0, 16)) - 16;
      1:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // With prefer_held, mostly handles now in the heap, so decrease-key does work.
  function automatic logic [HANDLE_WIDTH-1:0] random_handle(bit prefer_held);
    if (prefer_held && shadow_fill > 0 && $urandom_range(0, 9) < 7)
      return shadow_handle[$urandom_range(0, shadow_fill - 1)];
    if ($urandom_range(0, 1)) return HANDLE_WIDTH'($urandom_range(0, 15));
    return HANDLE_WIDTH'($urandom);
  endfunction

  // --------------------------------------------------------------------------
  // Operation side. Called at a falling edge; returns at a falling edge just
  // after the item has been taken. The expected result is queued before the
  // item is offered, which is safe since no result can come before acceptance.
  // --------------------------------------------------------------------------
  task automatic send_op(logic [1:0] op, logic signed [KEY_WIDTH-1:0] k,
                         logic [HANDLE_WIDTH-1:0] h, bit typed, heap_result_t want);
    heap_result_t predicted;
    int unsigned  gap;
    predicted = apply_heap_op(op, k, h);
    expected_results.push_back(typed ? want : predicted);
    sent_per_mode[op]++;
    gap = tx_calm ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      op_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    op_valid  <= 1'b1;
    op_mode   <= op;
    op_key    <= k;
    op_handle <= h;
    do @(posedge clk); while (op_stall);
    @(negedge clk);
  endtask

  // Holds the operation side idle until every outstanding result is back.
  task automatic drain_results();
    op_valid <= 1'b0;
    @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  // Capacity writes happen only with the block idle.
  task automatic write_capacity(logic [CAP_W-1:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we     <= 1'b0;
    shadow_cap  = int'(v);
    cap_writes++;
  endtask

  // --------------------------------------------------------------------------
  // Result side: for each result it draws a number of stall cycles, then
  // lowers the stall until a result is taken.
  // --------------------------------------------------------------------------
  initial begin : result_pacing
    int unsigned hold;
    res_stall = 1'b0;
    @(negedge clk);
    forever begin
      hold = rx_calm ? 0 : $urandom_range(0, 11);
      res_stall <= (hold != 0);
      while (hold != 0) begin
        @(negedge clk);
        hold--;
        res_stall <= (hold != 0);
      end
      do @(posedge clk); while (!(res_valid && !res_stall));
      @(negedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Result checker. Values are sampled at the rising edge, before the block's
  // own updates for that edge take effect.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    heap_result_t got;
    heap_result_t want;
    if (!rst && res_valid && !res_stall) begin
      got = {status, min_key, min_handle, entry_count};
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("[%0t] unexpected result: status=%0d key=%0d handle=%0h count=%0d",
                   $realtime, got.status, got.min_key, got.min_handle, got.entry_count);
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status || got.min_key !== want.min_key ||
            got.min_handle !== want.min_handle || got.entry_count !== want.entry_count)
        begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"[%0t] result mismatch: expected status=%0d key=%0d handle=%0h ",
                      "count=%0d, got status=%0d key=%0d handle=%0h count=%0d"},
                     $realtime, want.status, want.min_key, want.min_handle,
                     want.entry_count, got.status, got.min_key, got.min_handle,
                     got.entry_count);
        end else begin
          results_ok++;
        end
      end
    end
  end

  // Guard against a hung handshake. The slowest legal run, with every item
  // paying a full handle scan plus the longest gaps on both sides, stays
  // under this limit.
  initial begin : watchdog
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    heap_row_t        row;
    logic [CAP_W-1:0] cap;
    int               ins_pct;
    int               pick;
    logic [1:0]       op;

    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_data  = '0;
    op_valid  = 1'b0;
    op_mode   = MODE_INSERT;
    op_key    = '0;
    op_handle = '0;
    foreach (sent_per_mode[i]) sent_per_mode[i] = 0;

    // Directed table. Rows with a hand-typed result use values that follow
    // directly from the operation; the others rely on the shadow heap.
    // Empty heap: extract reports empty, decrease misses, unused mode is a no-op.
    plan_checked(MODE_EXTRACT, 32'sd0, 16'h0000, STATUS_EMPTY, 32'sd0, 16'h0000, 0);
    plan_checked(MODE_DECREASE, 32'sd5, 16'h0005, STATUS_NOT_FOUND, 32'sd0, 16'h0000, 0);
    plan_checked(MODE_UNUSED, -32'sd1, 16'hFFFF, STATUS_OK, 32'sd0, 16'h0000, 0);
    // Key and handle extremes, equal keys, and a duplicate handle.
    plan_checked(MODE_INSERT, 32'sh7FFF_FFFF, 16'hFFFF, STATUS_OK, 32'sd0, 16'h0000, 1);
    plan_checked(MODE_INSERT, 32'sh8000_0000, 16'h0000, STATUS_OK, 32'sd0, 16'h0000, 2);
    plan_checked(MODE_INSERT, 32'sd0, 16'h0005, STATUS_OK, 32'sd0, 16'h0000, 3);
    plan_checked(MODE_INSERT, 32'sd0, 16'h0006, STATUS_OK, 32'sd0, 16'h0000, 4);
    plan_checked(MODE_INSERT, 32'sd100, 16'h0005, STATUS_OK, 32'sd0, 16'h0000, 5);
    // Decrease on a duplicated handle, then a "decrease" to a larger key.
    plan_op(MODE_DECREASE, -32'sd5, 16'h0005);
    plan_op(MODE_DECREASE, 32'sd1000, 16'h0006);
    plan_checked(MODE_DECREASE, 32'sd7, 16'h1234, STATUS_NOT_FOUND, 32'sd0, 16'h0000, 5);
    plan_checked(MODE_UNUSED, 32'sd9, 16'h0005, STATUS_OK, 32'sd0, 16'h0000, 5);
    // Drain the heap and run one past empty.
    plan_checked(MODE_EXTRACT, 32'sd0, 16'h0000, STATUS_OK, 32'sh8000_0000, 16'h0000, 4);
    repeat (4) plan_op(MODE_EXTRACT, 32'sd0, 16'h0000);
    plan_checked(MODE_EXTRACT, 32'sd0, 16'h0000, STATUS_EMPTY, 32'sd0, 16'h0000, 0);
    // Zero capacity overflows at once; capacity one holds a single entry.
    plan_capacity(9'd0);
    plan_checked(MODE_INSERT, 32'sd3, 16'h0003, STATUS_OVERFLOW, 32'sd0, 16'h0000, 0);
    plan_capacity(9'd1);
    plan_checked(MODE_INSERT, 32'sd4, 16'h0004, STATUS_OK, 32'sd0, 16'h0000, 1);
    plan_checked(MODE_INSERT, 32'sd5, 16'h0005, STATUS_OVERFLOW, 32'sd0, 16'h0000, 1);
    // Capacity dropped below the fill: inserts overflow, entries are kept.
    plan_capacity(9'd256);
    plan_op(MODE_INSERT, 32'sd9, 16'h0009);
    plan_op(MODE_INSERT, -32'sd9, 16'h000A);
    plan_capacity(9'd2);
    plan_checked(MODE_INSERT, 32'sd1, 16'h0001, STATUS_OVERFLOW, 32'sd0, 16'h0000, 3);
    plan_op(MODE_EXTRACT, 32'sd0, 16'h0000);

    // Reset is held from time zero and released on a falling edge.
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_cap) begin
        drain_results();
        write_capacity(row.cap);
      end else begin
        send_op(row.op, row.k, row.h, row.typed, row.want);
      end
    end

    // Fill to the full depth with a capacity setting above it, overflow once,
    // search a full heap, then empty it again.
    drain_results();
    write_capacity(9'd511);
    while (shadow_fill < DEPTH)
      send_op(MODE_INSERT, random_key(), random_handle(1'b0), 1'b0, '0);
    send_op(MODE_INSERT, random_key(), random_handle(1'b0), 1'b1,
            {STATUS_OVERFLOW, 32'sd0, 16'h0000, CNT_W'(DEPTH)});
    repeat (4) send_op(MODE_DECREASE, random_key(), random_handle(1'b1), 1'b0, '0);
    send_op(MODE_DECREASE, random_key(), HANDLE_WIDTH'($urandom), 1'b0, '0);
    while (shadow_fill > 0)
      send_op(MODE_EXTRACT, random_key(), HANDLE_WIDTH'($urandom), 1'b0, '0);

    // Random phases, each at its own capacity and with its own pacing. Some
    // phases run with no gaps on one side or the other.
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0:       cap = 9'd256;
        1:       cap = 9'd3;
        2:       cap = 9'd511;
        3:       cap = 9'd1;
        4:       cap = 9'd0;
        5:       cap = 9'd40;
        6:       cap = 9'd300;
        7:       cap = 9'd8;
        default: cap = CAP_W'($urandom_range(0, 511));
      endcase
      drain_results();
      write_capacity(cap);
      tx_calm = (phase % 3 == 2);
      rx_calm = (phase % 4 == 1);
      ins_pct = (cap >= 40) ? 55 : 40;
      repeat (65) begin
        pick = $urandom_range(0, 99);
        if (pick < 3)                 op = MODE_UNUSED;
        else if (pick < ins_pct)      op = MODE_INSERT;
        else if (pick < ins_pct + 22) op = MODE_DECREASE;
        else                          op = MODE_EXTRACT;
        send_op(op, random_key(), random_handle(op == MODE_DECREASE), 1'b0, '0);
      end
    end

    // Wait for the tail, then give any stray result a chance to show up.
    drain_results();
    repeat (40) @(posedge clk);
    if (expected_results.size() != 0) begin
      mismatch_count += expected_results.size();
      $display("%0d expected results never arrived", expected_results.size());
    end

    $display("Sent %0d inserts, %0d decrease-keys, %0d extracts and %0d unused-mode items.",
             sent_per_mode[MODE_INSERT], sent_per_mode[MODE_DECREASE],
             sent_per_mode[MODE_EXTRACT], sent_per_mode[MODE_UNUSED]);
    $display("%0d capacity writes, heap peaked at %0d entries, %0d results matched, %0d bad.",
             cap_writes, peak_fill, results_ok, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
